// File: rtl/core/god_pkg.sv
// god_pkg: shared types and constants for the glyph outline decoder.
// Used by god_ctrl, god_datapath and glyph_outline_decoder_unit.
`timescale 1ns / 1ps

package god_pkg;

	localparam int MAX_POINTS_DEF   = 64;
	localparam int MAX_CONTOURS_DEF = 16;
	localparam int END_MAP_N        = 64;
	localparam int HDR_LAST_BYTE    = 9;
	localparam int CHEAD_LAST_BYTE  = 3;

	localparam logic [1:0] KIND_HEADER    = 2'd0;
	localparam logic [1:0] KIND_POINT     = 2'd1;
	localparam logic [1:0] KIND_COMPONENT = 2'd2;
	localparam logic [1:0] KIND_ERROR     = 2'd3;

	// coordinate encodings taken from the flag bits
	localparam logic [1:0] MODE_WORD = 2'd0;
	localparam logic [1:0] MODE_NEG  = 2'd1;
	localparam logic [1:0] MODE_SAME = 2'd2;
	localparam logic [1:0] MODE_POS  = 2'd3;

	localparam int FLAG_REPEAT_BIT = 3;

	localparam int CF_ARGS_WORDS_BIT = 0;
	localparam int CF_SCALE_BIT      = 3;
	localparam int CF_MORE_BIT       = 5;
	localparam int CF_XY_SCALE_BIT   = 6;
	localparam int CF_2X2_BIT        = 7;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_HDR_WORD,
		OP_HDR_EMIT,
		OP_ERR_EMIT,
		OP_END_WORD,
		OP_ILEN,
		OP_SKIP_DEC,
		OP_FLAG_NEW,
		OP_FLAG_REP,
		OP_FLAG_COPY,
		OP_COORD_INIT,
		OP_RD,
		OP_COORD_BYTE,
		OP_COMMIT,
		OP_CHEAD,
		OP_CARG1,
		OP_CEMIT
	} dp_op_t;

	typedef struct packed {
		logic       load;
		logic       restart;
		dp_op_t     op;
		logic       axis;
		logic [1:0] hdr_sel;
		logic       final_byte;
		logic       arg_word;
	} dp_cmd_t;

	typedef struct packed {
		logic       cc_neg;
		logic       cc_bad;
		logic       end_last;
		logic       too_big;
		logic       word_nz;
		logic       skip_one;
		logic       rep_bit;
		logic       walk_next_ge;
		logic       walk_ge;
		logic       rep_go;
		logic [1:0] mode_x;
		logic [1:0] mode_y;
		logic       cf_words;
		logic       more;
		logic       cskip_nz;
	} dp_stat_t;

endpackage

// File: rtl/core/god_datapath.sv
// god_datapath: byte assembly, flag and x stores, coordinate sums, result register.
// Depends on god_pkg; driven by god_ctrl commands.
`timescale 1ns / 1ps

module god_datapath import god_pkg::*; #(
	parameter int MAX_POINTS   = MAX_POINTS_DEF,
	parameter int MAX_CONTOURS = MAX_CONTOURS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	output logic               strobe,
	output logic [1:0]         record_kind,
	output logic [5:0]         item_index,
	output logic signed [15:0] x_value,
	output logic signed [15:0] y_value,
	output logic signed [15:0] box_x_max,
	output logic signed [15:0] box_y_max,
	output logic signed [15:0] contour_count,
	output logic               on_curve,
	output logic               contour_end,
	output logic [15:0]        component_flags,
	output logic [15:0]        component_glyph,
	output logic               last
);

	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int WMAX = (MAX_POINTS > MAX_CONTOURS) ? MAX_POINTS : MAX_CONTOURS;
	localparam int WW   = $clog2(WMAX + 1);
	localparam int PW   = $clog2(MAX_POINTS + 1);
	localparam int CW   = $clog2(MAX_CONTOURS + 1);

	logic [7:0]          byte_q;
	logic [7:0]          pw_q;
	logic [15:0]         hw_q [0:3];
	logic [WW-1:0]       walk_q;
	logic [CW-1:0]       ct_q;
	logic [PW-1:0]       pt_q;
	logic [15:0]         skip_q;
	logic [7:0]          rep_q;
	logic [4:0]          last_flag_q;
	logic [15:0]         run_q;
	logic [47:0]         cf_q;
	logic [5:0]          cn_q;
	logic [END_MAP_N-1:0] end_map_q;
	logic [4:0]          fl_rd_q;
	logic [15:0]         x_rd_q;
	logic [4:0]          fl_mem [0:MAX_POINTS-1];
	logic [15:0]         x_mem  [0:MAX_POINTS-1];

	logic [15:0] word;
	logic [4:0]  flag_pk;
	logic [1:0]  mode;
	logic [15:0] delta;
	logic [15:0] run_nx;
	logic [15:0] commit_val;
	logic [WW:0] walk_inc;
	logic [15:0] arg;
	logic [15:0] cflags;
	logic [15:0] cskip_val;
	logic [5:0]  end_idx;
	logic [5:0]  walk6;
	logic        commit_en;

	assign word     = {pw_q, byte_q};
	assign flag_pk  = {byte_q[5:4], byte_q[2:0]};
	assign walk_inc = {1'b0, walk_q} + {{WW{1'b0}}, 1'b1};
	assign walk6    = 6'(walk_q);
	assign cflags   = cf_q[47:32];
	assign end_idx  = (word > 16'd63) ? 6'd63 : word[5:0];
	assign arg      = cmd.arg_word ? word : {{8{byte_q[7]}}, byte_q};
	assign mode     = cmd.axis ? {fl_rd_q[4], fl_rd_q[2]} : {fl_rd_q[3], fl_rd_q[1]};

	always_comb begin
		unique case (mode)
			MODE_WORD: delta = word;
			MODE_NEG:  delta = 16'd0 - {8'd0, byte_q};
			MODE_POS:  delta = {8'd0, byte_q};
			default:   delta = 16'd0;
		endcase
	end

	assign run_nx     = run_q + delta;
	assign commit_val = (cmd.op == OP_COORD_BYTE) ? run_nx : run_q;
	assign commit_en  = (cmd.op == OP_COORD_BYTE) || (cmd.op == OP_COMMIT);

	always_comb begin
		priority if (cflags[CF_SCALE_BIT])    cskip_val = 16'd2;
		else if (cflags[CF_XY_SCALE_BIT])     cskip_val = 16'd4;
		else if (cflags[CF_2X2_BIT])          cskip_val = 16'd8;
		else                                  cskip_val = 16'd0;
	end

	always_comb begin
		stat.cc_neg       = hw_q[0][15];
		stat.cc_bad       = !hw_q[0][15] &&
		                    ((hw_q[0] == 16'd0) || (hw_q[0] > 16'(MAX_CONTOURS)));
		stat.end_last     = walk_inc >= (WW+1)'(ct_q);
		stat.too_big      = word >= 16'(MAX_POINTS);
		stat.word_nz      = word != 16'd0;
		stat.skip_one     = skip_q == 16'd1;
		stat.rep_bit      = byte_q[FLAG_REPEAT_BIT];
		stat.walk_next_ge = walk_inc >= (WW+1)'(pt_q);
		stat.walk_ge      = walk_q >= WW'(pt_q);
		stat.rep_go       = (rep_q != 8'd0) && (walk_q < WW'(pt_q)) && (walk_q != '0);
		stat.mode_x       = {fl_rd_q[3], fl_rd_q[1]};
		stat.mode_y       = {fl_rd_q[4], fl_rd_q[2]};
		stat.cf_words     = cflags[CF_ARGS_WORDS_BIT];
		stat.more         = cflags[CF_MORE_BIT];
		stat.cskip_nz     = cskip_val != 16'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FLAG_NEW) begin
			fl_mem[walk_q[AW-1:0]] <= flag_pk;
		end else if (cmd.op == OP_FLAG_COPY) begin
			fl_mem[walk_q[AW-1:0]] <= last_flag_q;
		end
		if (commit_en && !cmd.axis) begin
			x_mem[walk_q[AW-1:0]] <= commit_val;
		end
		if (cmd.op == OP_RD) begin
			fl_rd_q <= fl_mem[walk_q[AW-1:0]];
			x_rd_q  <= x_mem[walk_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q          <= '0;
			pw_q            <= '0;
			hw_q            <= '{default: '0};
			walk_q          <= '0;
			ct_q            <= '0;
			pt_q            <= '0;
			skip_q          <= '0;
			rep_q           <= '0;
			last_flag_q     <= '0;
			run_q           <= '0;
			cf_q            <= '0;
			cn_q            <= '0;
			end_map_q       <= '0;
			strobe          <= 1'b0;
			record_kind     <= KIND_HEADER;
			item_index      <= '0;
			x_value         <= '0;
			y_value         <= '0;
			box_x_max       <= '0;
			box_y_max       <= '0;
			contour_count   <= '0;
			on_curve        <= 1'b0;
			contour_end     <= 1'b0;
			component_flags <= '0;
			component_glyph <= '0;
			last            <= 1'b0;
		end else begin
			strobe          <= 1'b0;
			record_kind     <= KIND_HEADER;
			item_index      <= '0;
			x_value         <= '0;
			y_value         <= '0;
			box_x_max       <= '0;
			box_y_max       <= '0;
			contour_count   <= '0;
			on_curve        <= 1'b0;
			contour_end     <= 1'b0;
			component_flags <= '0;
			component_glyph <= '0;
			last            <= 1'b0;
			if (cmd.load) begin
				byte_q <= data_byte;
			end
			if (cmd.restart) begin
				cn_q      <= '0;
				cf_q      <= '0;
				end_map_q <= '0;
			end
			unique case (cmd.op)
				OP_LATCH: begin
					pw_q <= byte_q;
				end
				OP_HDR_WORD: begin
					hw_q[cmd.hdr_sel] <= word;
				end
				OP_HDR_EMIT: begin
					strobe        <= 1'b1;
					record_kind   <= KIND_HEADER;
					x_value       <= hw_q[1];
					y_value       <= hw_q[2];
					box_x_max     <= hw_q[3];
					box_y_max     <= word;
					contour_count <= hw_q[0];
					walk_q        <= '0;
					ct_q          <= hw_q[0][CW-1:0];
				end
				OP_ERR_EMIT: begin
					strobe      <= 1'b1;
					record_kind <= KIND_ERROR;
					last        <= 1'b1;
				end
				OP_END_WORD: begin
					end_map_q[end_idx] <= 1'b1;
					walk_q             <= walk_inc[WW-1:0];
					if (stat.end_last && !stat.too_big) begin
						pt_q <= word[PW-1:0] + PW'(1);
					end
				end
				OP_ILEN: begin
					skip_q <= word;
					walk_q <= '0;
				end
				OP_SKIP_DEC: begin
					skip_q <= skip_q - 16'd1;
				end
				OP_FLAG_NEW: begin
					last_flag_q <= flag_pk;
					walk_q      <= walk_inc[WW-1:0];
				end
				OP_FLAG_REP: begin
					rep_q <= byte_q;
				end
				OP_FLAG_COPY: begin
					walk_q <= walk_inc[WW-1:0];
					rep_q  <= rep_q - 8'd1;
				end
				OP_COORD_INIT: begin
					walk_q <= '0;
					run_q  <= '0;
				end
				OP_COORD_BYTE, OP_COMMIT: begin
					run_q  <= commit_val;
					walk_q <= walk_inc[WW-1:0];
					if (cmd.axis) begin
						strobe      <= 1'b1;
						record_kind <= KIND_POINT;
						item_index  <= walk6;
						x_value     <= x_rd_q;
						y_value     <= commit_val;
						on_curve    <= fl_rd_q[0];
						contour_end <= end_map_q[walk6];
						last        <= stat.walk_next_ge;
					end
				end
				OP_CHEAD: begin
					if (cmd.final_byte) begin
						cf_q <= {cf_q[23:0], byte_q, 16'h0000};
					end else begin
						cf_q <= {16'h0000, cf_q[23:0], byte_q};
					end
				end
				OP_CARG1: begin
					cf_q <= cf_q | {32'h0, arg};
				end
				OP_CEMIT: begin
					strobe          <= 1'b1;
					record_kind     <= KIND_COMPONENT;
					item_index      <= cn_q;
					x_value         <= cf_q[15:0];
					y_value         <= arg;
					component_flags <= cflags;
					component_glyph <= cf_q[31:16];
					last            <= !cflags[CF_MORE_BIT];
					cn_q            <= cn_q + 6'd1;
					cf_q            <= '0;
					skip_q          <= cskip_val;
				end
				OP_NONE, OP_RD: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/core/god_ctrl.sv
// god_ctrl: parse sequencer for the glyph outline decoder.
// Depends on god_pkg; issues commands to god_datapath and reads its status.
`timescale 1ns / 1ps

module god_ctrl import god_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     glyph_start,
	input  dp_stat_t stat,
	output logic     busy,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_HEADER, PH_ENDS, PH_ILEN, PH_ISKIP, PH_FLAGS,
		PH_XC, PH_YC, PH_CHEAD, PH_CARGS, PH_CSKIP
	} ph_t;

	typedef enum logic [2:0] {
		S_WAIT, S_BYTE, S_ERR, S_REP, S_INIT, S_RD, S_EVAL
	} st_t;

	ph_t        ph_q, ph_d, eph;
	st_t        st_q, st_d;
	logic [3:0] bp_q, bp_d, ebp;
	logic       rp_q, rp_d, erp;
	logic       gs_q;
	logic [1:0] cur_mode;

	assign busy     = st_q != S_WAIT;
	assign eph      = gs_q ? PH_HEADER : ph_q;
	assign ebp      = gs_q ? 4'd0 : bp_q;
	assign erp      = gs_q ? 1'b0 : rp_q;
	assign cur_mode = (ph_q == PH_YC) ? stat.mode_y : stat.mode_x;

	always_comb begin
		cmd            = '0;
		cmd.op         = OP_NONE;
		cmd.axis       = ph_q == PH_YC;
		ph_d           = ph_q;
		bp_d           = bp_q;
		rp_d           = rp_q;
		st_d           = st_q;
		unique case (st_q)
			S_WAIT: begin
				if (start) begin
					cmd.load = 1'b1;
					st_d     = S_BYTE;
				end
			end
			S_BYTE: begin
				cmd.restart = gs_q;
				cmd.axis    = eph == PH_YC;
				ph_d        = eph;
				bp_d        = ebp;
				rp_d        = erp;
				st_d        = S_WAIT;
				unique case (eph)
					PH_HEADER: begin
						if (ebp == 4'(HDR_LAST_BYTE)) begin
							cmd.op = OP_HDR_EMIT;
							bp_d   = 4'd0;
							priority if (stat.cc_neg) begin
								ph_d = PH_CHEAD;
							end else if (stat.cc_bad) begin
								ph_d = PH_IDLE;
								st_d = S_ERR;
							end else begin
								ph_d = PH_ENDS;
							end
						end else begin
							cmd.op      = ebp[0] ? OP_HDR_WORD : OP_LATCH;
							cmd.hdr_sel = ebp[2:1];
							bp_d        = ebp + 4'd1;
						end
					end
					PH_ENDS: begin
						if (ebp == 4'd0) begin
							cmd.op = OP_LATCH;
							bp_d   = 4'd1;
						end else begin
							cmd.op = OP_END_WORD;
							bp_d   = 4'd0;
							if (stat.end_last) begin
								if (stat.too_big) begin
									ph_d = PH_IDLE;
									st_d = S_ERR;
								end else begin
									ph_d = PH_ILEN;
								end
							end
						end
					end
					PH_ILEN: begin
						if (ebp == 4'd0) begin
							cmd.op = OP_LATCH;
							bp_d   = 4'd1;
						end else begin
							cmd.op = OP_ILEN;
							bp_d   = 4'd0;
							rp_d   = 1'b0;
							ph_d   = stat.word_nz ? PH_ISKIP : PH_FLAGS;
						end
					end
					PH_ISKIP: begin
						cmd.op = OP_SKIP_DEC;
						if (stat.skip_one) begin
							ph_d = PH_FLAGS;
						end
					end
					PH_FLAGS: begin
						if (erp) begin
							cmd.op = OP_FLAG_REP;
							rp_d   = 1'b0;
							st_d   = S_REP;
						end else begin
							cmd.op = OP_FLAG_NEW;
							if (stat.rep_bit) begin
								rp_d = 1'b1;
							end else if (stat.walk_next_ge) begin
								st_d = S_INIT;
							end
						end
					end
					PH_XC, PH_YC: begin
						if (cur_mode == MODE_WORD && ebp == 4'd0) begin
							cmd.op = OP_LATCH;
							bp_d   = 4'd1;
						end else begin
							cmd.op = OP_COORD_BYTE;
							bp_d   = 4'd0;
							st_d   = S_RD;
						end
					end
					PH_CHEAD: begin
						cmd.op = OP_CHEAD;
						if (ebp == 4'(CHEAD_LAST_BYTE)) begin
							cmd.final_byte = 1'b1;
							bp_d           = 4'd0;
							ph_d           = PH_CARGS;
						end else begin
							bp_d = ebp + 4'd1;
						end
					end
					PH_CARGS: begin
						cmd.arg_word = stat.cf_words;
						if (stat.cf_words && (ebp == 4'd0 || ebp == 4'd2)) begin
							cmd.op = OP_LATCH;
							bp_d   = ebp + 4'd1;
						end else if ((stat.cf_words && ebp == 4'd1) ||
						             (!stat.cf_words && ebp == 4'd0)) begin
							cmd.op = OP_CARG1;
							bp_d   = stat.cf_words ? 4'd2 : 4'd1;
						end else begin
							cmd.op = OP_CEMIT;
							bp_d   = 4'd0;
							priority if (!stat.more) begin
								ph_d = PH_IDLE;
							end else if (stat.cskip_nz) begin
								ph_d = PH_CSKIP;
							end else begin
								ph_d = PH_CHEAD;
							end
						end
					end
					PH_CSKIP: begin
						cmd.op = OP_SKIP_DEC;
						if (stat.skip_one) begin
							bp_d = 4'd0;
							ph_d = PH_CHEAD;
						end
					end
					default: begin
						ph_d = PH_IDLE;
					end
				endcase
			end
			S_ERR: begin
				cmd.op = OP_ERR_EMIT;
				ph_d   = PH_IDLE;
				st_d   = S_WAIT;
			end
			S_REP: begin
				priority if (stat.rep_go) begin
					cmd.op = OP_FLAG_COPY;
				end else if (stat.walk_ge) begin
					st_d = S_INIT;
				end else begin
					st_d = S_WAIT;
				end
			end
			S_INIT: begin
				cmd.op = OP_COORD_INIT;
				ph_d   = PH_XC;
				bp_d   = 4'd0;
				st_d   = S_RD;
			end
			S_RD: begin
				cmd.op = OP_RD;
				st_d   = S_EVAL;
			end
			S_EVAL: begin
				priority if (stat.walk_ge) begin
					if (ph_q == PH_XC) begin
						cmd.op = OP_COORD_INIT;
						ph_d   = PH_YC;
						bp_d   = 4'd0;
						st_d   = S_RD;
					end else begin
						ph_d = PH_IDLE;
						st_d = S_WAIT;
					end
				end else if (cur_mode == MODE_SAME) begin
					cmd.op = OP_COMMIT;
					st_d   = S_RD;
				end else begin
					st_d = S_WAIT;
				end
			end
			default: begin
				st_d = S_WAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			st_q <= S_WAIT;
			bp_q <= '0;
			rp_q <= 1'b0;
			gs_q <= 1'b0;
		end else begin
			ph_q <= ph_d;
			st_q <= st_d;
			bp_q <= bp_d;
			rp_q <= rp_d;
			if (st_q == S_WAIT && start) begin
				gs_q <= glyph_start;
			end
		end
	end

endmodule

// File: rtl/core/glyph_outline_decoder_unit.sv
// Glyph outline decoder: one record byte per request, results on a one-cycle strobe.
// Results: a result is strobed in the cycle after the first busy cycle of its request; a header
// error result follows in the cycle after the header. A request is taken only while busy is low;
// a coordinate byte that completes a value reads the flag/x stores (single-port), a repeat count
// copies flags one at a time, and unchanged coordinates, the flags' end and x to y switch add reads.
// Reset: asynchronous, active low; block returns to waiting for a glyph start.
`timescale 1ns / 1ps

module glyph_outline_decoder_unit import god_pkg::*; #(
	parameter int MAX_POINTS   = MAX_POINTS_DEF,
	parameter int MAX_CONTOURS = MAX_CONTOURS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         data_byte,
	input  logic               glyph_start,
	output logic               strobe,
	output logic [1:0]         record_kind,
	output logic [5:0]         item_index,
	output logic signed [15:0] x_value,
	output logic signed [15:0] y_value,
	output logic signed [15:0] box_x_max,
	output logic signed [15:0] box_y_max,
	output logic signed [15:0] contour_count,
	output logic               on_curve,
	output logic               contour_end,
	output logic [15:0]        component_flags,
	output logic [15:0]        component_glyph,
	output logic               last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	god_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.glyph_start (glyph_start),
		.stat        (stat),
		.busy        (busy),
		.cmd         (cmd)
	);

	god_datapath #(
		.MAX_POINTS   (MAX_POINTS),
		.MAX_CONTOURS (MAX_CONTOURS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.data_byte       (data_byte),
		.cmd             (cmd),
		.stat            (stat),
		.strobe          (strobe),
		.record_kind     (record_kind),
		.item_index      (item_index),
		.x_value         (x_value),
		.y_value         (y_value),
		.box_x_max       (box_x_max),
		.box_y_max       (box_y_max),
		.contour_count   (contour_count),
		.on_curve        (on_curve),
		.contour_end     (contour_end),
		.component_flags (component_flags),
		.component_glyph (component_glyph),
		.last            (last)
	);

	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result without a request in progress");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && record_kind == KIND_ERROR |-> last)
		else $error("error result not marked last");

	a_point_marks: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && record_kind != KIND_POINT |-> !on_curve && !contour_end)
		else $error("point marks on a non-point result");

	a_box_only_header: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && record_kind != KIND_HEADER |-> box_x_max == 16'sd0 && contour_count == 16'sd0)
		else $error("header fields on a non-header result");

endmodule

// File: bench/tb_glyph_outline_decoder_unit.sv
// Self-checking bench for glyph_outline_decoder_unit: glyph records go in a byte per request.
// An in-bench decoder predicts each result and the strobe output is checked against it.
// Depends on god_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_glyph_outline_decoder_unit import god_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 330;
	localparam int CALM_TAIL   = 60;

	typedef enum int {
		S_IDLE, S_HEAD, S_ENDS, S_ILEN, S_ISKIP, S_FLAGS, S_XC, S_YC, S_CHEAD, S_CARGS, S_CSKIP
	} decode_phase_t;

	typedef struct {
		logic [1:0]  kind;
		logic [5:0]  idx;
		logic [15:0] x, y, xm, ym, cc;
		logic        on, ce;
		logic [15:0] cf, cg;
		logic        lst;
	} glyph_res_t;

	typedef struct packed {
		logic [7:0] d;
		logic       gs;
		logic       pin;
		logic [1:0] pin_kind;
	} stim_row_t;

	localparam stim_row_t DIRECTED [27] = '{
		'{8'h5A, 1'b0, 1'b0, KIND_HEADER},
		'{8'hFF, 1'b1, 1'b0, KIND_HEADER}, '{8'hFF, 1'b0, 1'b0, KIND_HEADER},
		'{8'h80, 1'b0, 1'b0, KIND_HEADER}, '{8'h00, 1'b0, 1'b0, KIND_HEADER},
		'{8'h80, 1'b0, 1'b0, KIND_HEADER}, '{8'h00, 1'b0, 1'b0, KIND_HEADER},
		'{8'h7F, 1'b0, 1'b0, KIND_HEADER}, '{8'hFF, 1'b0, 1'b0, KIND_HEADER},
		'{8'h7F, 1'b0, 1'b0, KIND_HEADER}, '{8'hFF, 1'b0, 1'b0, KIND_HEADER},
		'{8'h00, 1'b0, 1'b0, KIND_HEADER}, '{8'h00, 1'b0, 1'b0, KIND_HEADER},
		'{8'hFF, 1'b0, 1'b0, KIND_HEADER}, '{8'hFF, 1'b0, 1'b0, KIND_HEADER},
		'{8'h80, 1'b0, 1'b0, KIND_HEADER}, '{8'h7F, 1'b0, 1'b1, KIND_COMPONENT},
		'{8'h00, 1'b1, 1'b0, KIND_HEADER}, '{8'h00, 1'b0, 1'b0, KIND_HEADER},
		'{8'h00, 1'b0, 1'b0, KIND_HEADER}, '{8'h00, 1'b0, 1'b0, KIND_HEADER},
		'{8'h00, 1'b0, 1'b0, KIND_HEADER}, '{8'h00, 1'b0, 1'b0, KIND_HEADER},
		'{8'h00, 1'b0, 1'b0, KIND_HEADER}, '{8'h00, 1'b0, 1'b0, KIND_HEADER},
		'{8'h00, 1'b0, 1'b0, KIND_HEADER}, '{8'h00, 1'b0, 1'b1, KIND_ERROR}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [7:0]         data_byte = 8'h00;
	logic               glyph_start = 1'b0;
	logic               strobe;
	logic [1:0]         record_kind;
	logic [5:0]         item_index;
	logic signed [15:0] x_value, y_value, box_x_max, box_y_max, contour_count;
	logic               on_curve, contour_end;
	logic [15:0]        component_flags, component_glyph;
	logic               last;

	glyph_outline_decoder_unit DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// decoder state as predicted
	decode_phase_t phase = S_IDLE;
	int            byte_ph, ctot, ptotal, walk, comp_num;
	logic [15:0]   partial, run_coord, skip_left;
	logic [15:0]   hdr_words [5];
	logic [5:0]    end_pts [16];
	logic [4:0]    pt_flags [64];
	logic [15:0]   x_pos [64];
	logic          rep_pending;
	logic [47:0]   comp_fields;

	glyph_res_t    expected_results [$];
	glyph_res_t    got_res;
	stim_row_t     stim_q [$];
	bit            failed = 1'b0;
	int            cycles = 0;

	function automatic void push_res(logic [1:0] k, logic [5:0] i, logic [15:0] x, y, xm, ym,
			cc, logic on, ce, logic [15:0] cf, cg, logic lst);
		glyph_res_t r;
		r.kind = k; r.idx = i; r.x = x; r.y = y; r.xm = xm; r.ym = ym; r.cc = cc;
		r.on = on; r.ce = ce; r.cf = cf; r.cg = cg; r.lst = lst;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void push_error();
		phase = S_IDLE;
		push_res(KIND_ERROR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
	endfunction

	function automatic logic [1:0] coord_mode(int axis);
		logic [4:0] pf;
		pf = pt_flags[walk % 64];
		return {pf[3 + axis], pf[1 + axis]};
	endfunction

	function automatic void commit_point();
		int   w;
		logic ce;
		w = walk % 64;
		ce = 1'b0;
		if (phase == S_XC) begin
			x_pos[w] = run_coord;
		end else begin
			for (int c = 0; c < ctot && c < 16; c++)
				if (end_pts[c] == w)
					ce = 1'b1;
			push_res(KIND_POINT, 6'(w), x_pos[w], run_coord, 0, 0, 0, pt_flags[w][0], ce, 0, 0,
				w + 1 >= ptotal);
		end
		walk++;
	endfunction

	function automatic void walk_unchanged();
		while (1) begin
			if (walk >= ptotal) begin
				if (phase == S_XC) begin
					phase = S_YC; walk = 0; run_coord = 16'd0; byte_ph = 0;
					continue;
				end
				phase = S_IDLE;
				break;
			end
			if (coord_mode(phase == S_YC) != MODE_SAME)
				break;
			commit_point();
		end
	endfunction

	function automatic void emit_component(logic [15:0] arg2);
		logic [15:0] fl;
		fl = comp_fields[47:32];
		push_res(KIND_COMPONENT, 6'(comp_num), comp_fields[15:0], arg2, 0, 0, 0, 0, 0, fl,
			comp_fields[31:16], !fl[CF_MORE_BIT]);
		comp_num = (comp_num + 1) % 64;
		byte_ph = 0;
		comp_fields = '0;
		if (!fl[CF_MORE_BIT]) begin
			phase = S_IDLE;
			return;
		end
		if (fl[CF_SCALE_BIT]) skip_left = 16'd2;
		else if (fl[CF_XY_SCALE_BIT]) skip_left = 16'd4;
		else if (fl[CF_2X2_BIT]) skip_left = 16'd8;
		else skip_left = 16'd0;
		phase = (skip_left != 0) ? S_CSKIP : S_CHEAD;
	endfunction

	function automatic void predict_byte(logic [7:0] b, logic gs);
		logic [15:0] word, delta;
		logic [1:0]  mode;
		int          cnt;
		word = {partial[7:0], b};
		if (gs) begin
			phase = S_HEAD; byte_ph = 0; comp_num = 0; comp_fields = '0; rep_pending = 1'b0;
		end
		case (phase)
			S_HEAD: begin
				if (byte_ph % 2 == 0) partial = {8'h00, b};
				else hdr_words[(byte_ph / 2) % 5] = word;
				byte_ph++;
				if (byte_ph >= 10) begin
					push_res(KIND_HEADER, 0, hdr_words[1], hdr_words[2], hdr_words[3],
						hdr_words[4], hdr_words[0], 0, 0, 0, 0, 1'b0);
					byte_ph = 0;
					walk = 0;
					if (hdr_words[0][15]) phase = S_CHEAD;
					else if (hdr_words[0] == 0 || hdr_words[0] > 16) push_error();
					else begin
						ctot = int'(hdr_words[0]);
						phase = S_ENDS;
					end
				end
			end
			S_ENDS: begin
				if (byte_ph == 0) begin
					partial = {8'h00, b}; byte_ph = 1;
				end else begin
					byte_ph = 0;
					end_pts[walk % 16] = (word > 63) ? 6'd63 : word[5:0];
					walk++;
					if (walk >= ctot) begin
						if (int'(word) + 1 > 64) push_error();
						else begin
							ptotal = int'(word) + 1;
							phase = S_ILEN;
						end
					end
				end
			end
			S_ILEN: begin
				if (byte_ph == 0) begin
					partial = {8'h00, b}; byte_ph = 1;
				end else begin
					byte_ph = 0; skip_left = word; walk = 0; rep_pending = 1'b0;
					phase = (word != 0) ? S_ISKIP : S_FLAGS;
				end
			end
			S_ISKIP: begin
				skip_left--;
				if (skip_left == 0) phase = S_FLAGS;
			end
			S_FLAGS: begin
				if (rep_pending) begin
					cnt = int'(b);
					rep_pending = 1'b0;
					while (cnt > 0 && walk < ptotal && walk > 0) begin
						pt_flags[walk % 64] = pt_flags[(walk - 1) % 64];
						walk++;
						cnt--;
					end
				end else begin
					pt_flags[walk % 64] = {b[5:4], b[2:0]};
					walk++;
					if (b[FLAG_REPEAT_BIT]) rep_pending = 1'b1;
				end
				if (!rep_pending && walk >= ptotal) begin
					phase = S_XC; walk = 0; run_coord = 16'd0; byte_ph = 0;
					walk_unchanged();
				end
			end
			S_XC, S_YC: begin
				mode = coord_mode(phase == S_YC);
				if (mode == MODE_WORD && byte_ph == 0) begin
					partial = {8'h00, b}; byte_ph = 1;
				end else begin
					if (mode == MODE_WORD) begin
						byte_ph = 0; delta = word;
					end else if (mode == MODE_NEG) delta = 16'(-int'(b));
					else delta = {8'h00, b};
					run_coord = run_coord + delta;
					commit_point();
					walk_unchanged();
				end
			end
			S_CHEAD: begin
				comp_fields = {16'h0000, comp_fields[23:0], b};
				byte_ph++;
				if (byte_ph >= 4) begin
					comp_fields = comp_fields << 16;
					byte_ph = 0;
					phase = S_CARGS;
				end
			end
			S_CARGS: begin
				if (comp_fields[32 + CF_ARGS_WORDS_BIT]) begin
					if (byte_ph == 0 || byte_ph == 2) begin
						partial = {8'h00, b}; byte_ph++;
					end else if (byte_ph == 1) begin
						comp_fields[15:0] = comp_fields[15:0] | word;
						byte_ph = 2;
					end else emit_component(word);
				end else begin
					if (byte_ph == 0) begin
						comp_fields[15:0] = comp_fields[15:0] | {{8{b[7]}}, b};
						byte_ph = 1;
					end else emit_component({{8{b[7]}}, b});
				end
			end
			S_CSKIP: begin
				skip_left--;
				if (skip_left == 0) begin
					byte_ph = 0; comp_fields = '0; phase = S_CHEAD;
				end
			end
			default: phase = S_IDLE;
		endcase
	endfunction

	function automatic void add_byte(logic [7:0] d, logic gs = 1'b0);
		stim_row_t s;
		s = '{d, gs, 1'b0, KIND_HEADER};
		stim_q.insert(stim_q.size(), s);
	endfunction

	function automatic void add_word(logic [15:0] w);
		add_byte(w[15:8]);
		add_byte(w[7:0]);
	endfunction

	function automatic void add_header(logic [15:0] cc);
		add_byte(cc[15:8], 1'b1);
		add_byte(cc[7:0]);
		repeat (4) add_word(16'($urandom));
	endfunction

	function automatic void add_simple_glyph();
		int         nc, npts, cnt, fill, cut;
		int         ends [16];
		logic [7:0] f;
		logic [7:0] rec [$];
		logic [7:0] expanded [$];
		logic [1:0] m;
		nc = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
		npts = ($urandom_range(0, 14) == 0) ? $urandom_range(nc, 64) : $urandom_range(nc, 16);
		for (int c = 0; c < nc; c++) begin
			ends[c] = npts * (c + 1) / nc - 1;
			if (c < nc - 1 && $urandom_range(0, 7) == 0) ends[c] = $urandom_range(0, 65535);
		end
		if ($urandom_range(0, 11) == 0) ends[nc - 1] = $urandom_range(64, 65535);
		add_header(16'(nc));
		for (int c = 0; c < nc; c++) add_word(16'(ends[c]));
		if (ends[nc - 1] >= 64) return;
		cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
		rec.insert(rec.size(), 8'(cnt >> 8));
		rec.insert(rec.size(), 8'(cnt));
		repeat (cnt) rec.insert(rec.size(), 8'($urandom));
		while (expanded.size() < npts) begin
			f = 8'($urandom);
			rec.insert(rec.size(), f);
			expanded.insert(expanded.size(), f);
			if (f[FLAG_REPEAT_BIT]) begin
				cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
				rec.insert(rec.size(), 8'(cnt));
				fill = npts - expanded.size();
				repeat ((cnt < fill) ? cnt : fill) expanded.insert(expanded.size(), f);
			end
		end
		for (int axis = 0; axis < 2; axis++)
			foreach (expanded[i]) begin
				m = {expanded[i][4 + axis], expanded[i][1 + axis]};
				if (m == MODE_WORD) begin
					rec.insert(rec.size(), 8'($urandom));
					rec.insert(rec.size(), 8'($urandom));
				end else if (m != MODE_SAME) rec.insert(rec.size(), 8'($urandom));
			end
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, rec.size()) : rec.size();
		for (int i = 0; i < cut; i++) add_byte(rec[i]);
	endfunction

	function automatic void add_compound_glyph();
		int          ncomp;
		logic [15:0] fl;
		ncomp = $urandom_range(1, 4);
		add_header(16'(-$urandom_range(1, 32768)));
		for (int k = 0; k < ncomp; k++) begin
			fl = 16'($urandom);
			fl[CF_MORE_BIT] = (k < ncomp - 1);
			add_word(fl);
			add_word(16'($urandom));
			repeat (fl[CF_ARGS_WORDS_BIT] ? 4 : 2) add_byte(8'($urandom));
			if (fl[CF_MORE_BIT])
				repeat (fl[CF_SCALE_BIT] ? 2 : fl[CF_XY_SCALE_BIT] ? 4 : fl[CF_2X2_BIT] ? 8 : 0)
					add_byte(8'($urandom));
		end
		repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
	endfunction

	function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			failed = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("glyph_outline_decoder_unit regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected, kind %0d", record_kind);
				failed = 1'b1;
			end else begin
				got_res = expected_results.pop_front();
				check_field("record_kind", 16'(got_res.kind), 16'(record_kind));
				check_field("item_index", 16'(got_res.idx), 16'(item_index));
				check_field("x_value", got_res.x, x_value);
				check_field("y_value", got_res.y, y_value);
				check_field("box_x_max", got_res.xm, box_x_max);
				check_field("box_y_max", got_res.ym, box_y_max);
				check_field("contour_count", got_res.cc, contour_count);
				check_field("on_curve", 16'(got_res.on), 16'(on_curve));
				check_field("contour_end", 16'(got_res.ce), 16'(contour_end));
				check_field("component_flags", got_res.cf, component_flags);
				check_field("component_glyph", got_res.cg, component_glyph);
				check_field("last", 16'(got_res.lst), 16'(last));
			end
		end
	end

	initial begin
		stim_row_t row;
		int        r;
		foreach (DIRECTED[i]) stim_q.insert(stim_q.size(), DIRECTED[i]);
		while (stim_q.size() < $size(DIRECTED) + ITEM_TARGET) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				add_header(16'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 32767)));
			else if (r <= 2) add_compound_glyph();
			else add_simple_glyph();
			if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		foreach (stim_q[i]) begin
			row = stim_q[i];
			if (i < stim_q.size() - CALM_TAIL && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			start <= 1'b1;
			data_byte <= row.d;
			glyph_start <= row.gs;
			@(posedge clk);
			while (busy) @(posedge clk);
			predict_byte(row.d, row.gs);
			if (row.pin && (expected_results.size() == 0 ||
					expected_results[$].kind != row.pin_kind || !expected_results[$].lst)) begin
				$error("directed request %0d: final result kind not %0d", i, row.pin_kind);
				failed = 1'b1;
			end
		end
		start <= 1'b0;
		glyph_start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (!failed)
			$display("glyph_outline_decoder_unit regression: pass");
		else
			$display("glyph_outline_decoder_unit regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/god_pkg.sv
rtl/core/god_datapath.sv
rtl/core/god_ctrl.sv
rtl/core/glyph_outline_decoder_unit.sv
bench/tb_glyph_outline_decoder_unit.sv
